/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of the project.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, ignored while reset is high.
`define ASSERT_SYNC(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/drzp_pkg.sv */
// Shared constants and types of the digit run zero padder.
// No dependencies; used by the cell, the chain and the top level.
package drzp_pkg;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Chain control: every cell sees shift in the same cycle; only the tail cell takes feed.
   typedef struct packed {
      logic       shift;
      logic [7:0] feed;
   } drzp_chain_ctl_type;

endpackage

/* rtl/digit_run_zero_pad_top.sv */
// Top level of the digit run zero padder: run control, output register, cell chain.
// Depends on drzp_pkg and drzp_chain.
//
//   channel | direction | tdata           | tuser    | tlast
//   req_    | in        | [7:0] in_char   | -        | end_of_text
//   rsp_    | out       | [7:0] out_char  | run_last | text_last
//
// A byte outside an unfinished digit run goes straight to the output register. A digit of
// an unfull run is shifted into the chain with no transfer out. Ending a run drains all
// PAD_WIDTH cells of the chain, one byte a cycle while rsp_ is not stalled, then sends
// the non-digit that ended it, if any; a digit that fills the run or ends the text also
// starts the drain.
// Reset is synchronous and clears the run state and fills every cell with '0'.
// A stalled rsp_ holds the output register and freezes the drain; req_tready is low
// while the chain drains or its ending byte waits, or while a waiting output is not taken.
module digit_run_zero_pad_top
   import drzp_pkg::*;
#(
   parameter int PAD_WIDTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tuser,   // [0] run_last
   output logic       rsp_tlast
);

   localparam int CNT_W = $clog2(PAD_WIDTH + 1);
   localparam int IDX_W = (PAD_WIDTH > 1) ? $clog2(PAD_WIDTH) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_DRAIN = 2'd1;
   localparam logic [1:0] ST_TAIL  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             in_number_ff, in_number_in;
   logic             run_flushed_ff, run_flushed_in;
   logic [CNT_W-1:0] digit_count_ff, digit_count_in;
   logic [IDX_W-1:0] drain_idx_ff, drain_idx_in;
   logic             tail_pend_ff, tail_pend_in;
   logic [7:0]       tail_char_ff, tail_char_in;
   logic             last_ff, last_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_run_last_ff, rsp_run_last_in;
   logic             rsp_text_last_ff, rsp_text_last_in;

   drzp_chain_ctl_type chain_ctl;
   logic [7:0]         head_char;
   logic               can_load;
   logic               accept;
   logic               is_digit;
   logic               drain_end;
   logic [CNT_W-1:0]   count_inc;

   drzp_chain #(
      .PAD_WIDTH (PAD_WIDTH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (chain_ctl),
      .head_char (head_char)
   );

   always_comb begin
      // The output register can take a byte when empty or being drained this cycle.
      can_load   = !rsp_valid_ff || rsp_tready;
      req_tready = (state_ff == ST_IDLE) && can_load;
      accept     = req_tvalid && req_tready;
      is_digit   = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
      count_inc  = digit_count_ff + 1'b1;
      drain_end  = (drain_idx_ff == IDX_W'(PAD_WIDTH - 1));

      state_in         = state_ff;
      in_number_in     = in_number_ff;
      run_flushed_in   = run_flushed_ff;
      digit_count_in   = digit_count_ff;
      drain_idx_in     = drain_idx_ff;
      tail_pend_in     = tail_pend_ff;
      tail_char_in     = tail_char_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_char_in      = rsp_char_ff;
      rsp_run_last_in  = rsp_run_last_ff;
      rsp_text_last_in = rsp_text_last_ff;
      chain_ctl.shift  = 1'b0;
      chain_ctl.feed   = CHAR_ZERO;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_tlast;
               if (is_digit) begin
                  in_number_in = 1'b1;
                  if (run_flushed_ff) begin
                     // Run already full: pass the digit straight through.
                     rsp_valid_in     = 1'b1;
                     rsp_char_in      = req_tdata;
                     rsp_run_last_in  = 1'b1;
                     rsp_text_last_in = req_tlast;
                  end else begin
                     // Hold the digit at the chain tail; leading cells stay '0'.
                     chain_ctl.shift = 1'b1;
                     chain_ctl.feed  = req_tdata;
                     if (count_inc == CNT_W'(PAD_WIDTH)) begin
                        state_in       = ST_DRAIN;
                        tail_pend_in   = 1'b0;
                        run_flushed_in = 1'b1;
                        digit_count_in = '0;
                        drain_idx_in   = '0;
                     end else if (req_tlast) begin
                        state_in       = ST_DRAIN;
                        tail_pend_in   = 1'b0;
                        digit_count_in = '0;
                        drain_idx_in   = '0;
                     end else begin
                        digit_count_in = count_inc;
                     end
                  end
               end else begin
                  if (in_number_ff && !run_flushed_ff) begin
                     // Run ends short: drain the padded chain, then this byte.
                     state_in     = ST_DRAIN;
                     tail_pend_in = 1'b1;
                     tail_char_in = req_tdata;
                     drain_idx_in = '0;
                  end else begin
                     rsp_valid_in     = 1'b1;
                     rsp_char_in      = req_tdata;
                     rsp_run_last_in  = 1'b1;
                     rsp_text_last_in = req_tlast;
                  end
                  in_number_in   = 1'b0;
                  run_flushed_in = 1'b0;
                  digit_count_in = '0;
               end
               // End of text: start the next text from a clean run.
               if (req_tlast) begin
                  in_number_in   = 1'b0;
                  run_flushed_in = 1'b0;
                  digit_count_in = '0;
               end
            end
         end
         ST_DRAIN: begin
            if (can_load) begin
               // Shift the head out and refill the tail with '0'.
               chain_ctl.shift  = 1'b1;
               chain_ctl.feed   = CHAR_ZERO;
               rsp_valid_in     = 1'b1;
               rsp_char_in      = head_char;
               rsp_run_last_in  = drain_end && !tail_pend_ff;
               rsp_text_last_in = drain_end && !tail_pend_ff && last_ff;
               if (drain_end) begin
                  drain_idx_in = '0;
                  state_in     = tail_pend_ff ? ST_TAIL : ST_IDLE;
               end else begin
                  drain_idx_in = drain_idx_ff + 1'b1;
               end
            end
         end
         ST_TAIL: begin
            if (can_load) begin
               rsp_valid_in     = 1'b1;
               rsp_char_in      = tail_char_ff;
               rsp_run_last_in  = 1'b1;
               rsp_text_last_in = last_ff;
               tail_pend_in     = 1'b0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         in_number_ff   <= 1'b0;
         run_flushed_ff <= 1'b0;
         digit_count_ff <= '0;
         drain_idx_ff   <= '0;
         tail_pend_ff   <= 1'b0;
         last_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_number_ff   <= in_number_in;
         run_flushed_ff <= run_flushed_in;
         digit_count_ff <= digit_count_in;
         drain_idx_ff   <= drain_idx_in;
         tail_pend_ff   <= tail_pend_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      tail_char_ff     <= tail_char_in;
      rsp_char_ff      <= rsp_char_in;
      rsp_run_last_ff  <= rsp_run_last_in;
      rsp_text_last_ff <= rsp_text_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tuser  = rsp_run_last_ff;
   assign rsp_tlast  = rsp_text_last_ff;

endmodule

/* rtl/drzp_cell.sv */
// One byte cell of the digit chain: loads its right-hand neighbour on a shift.
// Depends on drzp_pkg.
module drzp_cell
   import drzp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  logic [7:0] nb_char,
   output logic [7:0] cell_char
);

   logic [7:0] char_ff;
   logic [7:0] char_in;

   always_comb begin
      char_in = shift ? nb_char : char_ff;
   end

   // Reset to the pad character, so an empty chain already reads as padding.
   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= CHAR_ZERO;
      end else begin
         char_ff <= char_in;
      end
   end

   assign cell_char = char_ff;

endmodule

/* rtl/drzp_chain.sv */
// Row of PAD_WIDTH byte cells shifting towards the head; the tail takes the feed byte.
// Depends on drzp_pkg and drzp_cell.
module drzp_chain
   import drzp_pkg::*;
#(
   parameter int PAD_WIDTH = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  drzp_chain_ctl_type ctl,
   output logic [7:0]         head_char
);

   logic [7:0] cell_q [PAD_WIDTH];

   for (genvar i = 0; i < PAD_WIDTH; i++) begin : g_cell
      logic [7:0] nb_char;
      if (i == PAD_WIDTH - 1) begin : g_tail
         assign nb_char = ctl.feed;
      end else begin : g_mid
         assign nb_char = cell_q[i + 1];
      end
      drzp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (ctl.shift),
         .nb_char   (nb_char),
         .cell_char (cell_q[i])
      );
   end

   assign head_char = cell_q[0];

endmodule

/* rtl/drzp_checker.sv */
// Port-level checks of the digit run zero padder, bound to the top level.
// Depends on assert_macros.svh, drzp_pkg and digit_run_zero_pad_top.
`include "assert_macros.svh"

module drzp_checker
   import drzp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [7:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   `ASSERT_ALWAYS(a_rsp_idle_after_reset, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")
   `ASSERT_SYNC(a_rsp_stall_holds,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser),
      "stalled rsp transfer changed")
   `ASSERT_SYNC(a_text_end_ends_run, rsp_tvalid && rsp_tlast |-> rsp_tuser, "text end without run end")
   `ASSERT_SYNC(a_no_take_when_blocked, req_tready && rsp_tvalid |-> rsp_tready,
      "input taken while output stalled")
   // A non-digit is either queued at once or starts the drain of a short run.
   `ASSERT_SYNC(a_plain_byte_progresses,
      req_tvalid && req_tready && (req_tdata < CHAR_ZERO || req_tdata > CHAR_NINE)
         |=> rsp_tvalid || !req_tready,
      "non-digit neither queued nor draining")

endmodule

bind digit_run_zero_pad_top drzp_checker u_drzp_checker (.*);

/* bench/digit_run_zero_pad_top_tb.sv */
// Self-checking bench for digit_run_zero_pad_top: drives text bytes, predicts the padded text.
// Depends on drzp_pkg and the RTL of digit_run_zero_pad_top; needs no file or argument.
// Directed texts come first, then a receiver hold-off, then random texts with idling.
module digit_run_zero_pad_top_tb
   import drzp_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAD_WIDTH   = 8;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       text_last;
   } padded_byte_type;

   // Receiver behaviour between hold-offs
   typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_char
   logic       req_tlast  = 1'b0;    // end_of_text
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic       rsp_tuser;            // [0] run_last
   logic       rsp_tlast;            // text_last

   digit_run_zero_pad_top #(.PAD_WIDTH(PAD_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Padding predictor: own copy of the run state, fills padded_q in transfer order
   // ---------------------------------------------------------------------------------------
   padded_byte_type padded_q[$];
   logic [7:0]      step_bytes[$];
   logic [7:0]      held_digits[PAD_WIDTH];
   bit              run_open;
   bit              run_full;
   int              held_count;
   int              mismatch_count;

   // Append the held digits, left-padded with '0' when asked
   function automatic void release_held(input bit pad);
      if (pad)
         for (int i = held_count; i < PAD_WIDTH; i++)
            step_bytes.push_back(CHAR_ZERO);
      for (int i = 0; i < held_count; i++)
         step_bytes.push_back(held_digits[i]);
   endfunction

   function automatic void pad_next_byte(input logic [7:0] ch, input logic last);
      bit              is_digit;
      padded_byte_type item;
      is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      step_bytes.delete();
      if (is_digit) begin
         run_open = 1'b1;
         if (run_full) begin
            step_bytes.push_back(ch);
         end else begin
            if (held_count < PAD_WIDTH) begin
               held_digits[held_count] = ch;
               held_count++;
            end
            if (held_count >= PAD_WIDTH) begin
               release_held(1'b0);
               run_full   = 1'b1;
               held_count = 0;
            end else if (last) begin
               release_held(1'b1);
            end
         end
      end else begin
         if (run_open && !run_full)
            release_held(1'b1);
         run_open   = 1'b0;
         run_full   = 1'b0;
         held_count = 0;
         step_bytes.push_back(ch);
      end
      for (int i = 0; i < step_bytes.size(); i++) begin
         item.out_char  = step_bytes[i];
         item.run_last  = (i == step_bytes.size() - 1);
         item.text_last = last && item.run_last;
         padded_q.push_back(item);
      end
      // a final byte starts the next text from scratch
      if (last) begin
         run_open   = 1'b0;
         run_full   = 1'b0;
         held_count = 0;
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result checker: compare every rsp_ transfer with the oldest predicted byte
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      padded_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (padded_q.size() == 0) begin
            $error("out_char: expected nothing, got %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = padded_q.pop_front();
            if (rsp_tdata !== want.out_char) begin
               $error("out_char: expected %h, got %h", want.out_char, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.text_last) begin
               $error("text_last: expected %b, got %b", want.text_last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: own stall pattern, plus long hold-offs counted here when a test asks for one
   // ---------------------------------------------------------------------------------------
   rx_mode_type rx_mode = RX_ALWAYS;
   int          hold_asked;
   int          hold_served;
   int          hold_left;
   int          rx_phase;

   always @(posedge clock) begin
      rx_phase <= rx_phase + 1;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         case (rx_mode)
            RX_ALWAYS:  rsp_tready <= 1'b1;
            RX_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: rsp_tready <= ((rx_phase % 7) < 4) || ((rx_phase % 13) == 5);
            default:    rsp_tready <= 1'b1;
         endcase
      end
   end

   // Watchdog
   int cycle_count;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------------
   bit gaps_on;
   int burst_left;

   // Offer one text byte and hold it until the transfer; called at a rising edge
   task automatic send_byte(input logic [7:0] ch, input logic last);
      int gap;
      pad_next_byte(ch, last);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and hold until every predicted byte has been taken
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (padded_q.size() != 0);
   endtask

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] random_other();
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
      return ch;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Non-digits at the byte extremes and just either side of the digit range
   task automatic test_plain_bytes();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h2F, 1'b0);   // '/' just below '0'
      send_byte(8'h3A, 1'b1);   // ':' just above '9'
   endtask

   // Short runs closed by a non-digit and by the end of the text
   task automatic test_short_runs();
      send_byte(CHAR_ZERO, 1'b0);
      send_byte(8'h2F, 1'b0);
      send_byte(CHAR_NINE, 1'b1);
   endtask

   // A run that fills the store, passes a further digit through, then ends on a non-digit;
   // then a run that fills the store on the final byte of the text
   task automatic test_full_runs();
      for (int i = 1; i <= PAD_WIDTH; i++)
         send_byte(CHAR_ZERO + 8'(i), 1'b0);
      send_byte(CHAR_NINE, 1'b0);
      send_byte(8'h3A, 1'b1);
      for (int i = 0; i < PAD_WIDTH; i++)
         send_byte(CHAR_NINE - 8'(i), i == PAD_WIDTH - 1);
   endtask

   // Stop the receiver for a long stretch while bytes keep coming, so the input stalls
   task automatic test_output_hold_off();
      rx_mode = RX_ALWAYS;
      hold_asked++;
      for (int k = 0; k < 5; k++) begin
         for (int i = 0; i < 3; i++)
            send_byte(random_digit(), 1'b0);
         send_byte(random_other(), k == 4);
      end
      wait_for_drain();
   endtask

   // Random texts of digit runs and other bytes, lengths clustered round the pad width
   task automatic test_random_texts(input int n_items);
      int sent;
      int len;
      int pick;
      bit end_here;
      sent = 0;
      while (sent < n_items) begin
         pick     = $urandom_range(0, 9);
         end_here = ($urandom_range(0, 5) == 0);
         if (pick < 6) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: len = $urandom_range(1, PAD_WIDTH - 1);
               6, 7:             len = PAD_WIDTH;
               default:          len = $urandom_range(PAD_WIDTH + 1, PAD_WIDTH + 6);
            endcase
            for (int i = 0; i < len; i++)
               send_byte(random_digit(), end_here && (i == len - 1));
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               send_byte((pick == 9) ? 8'($urandom_range(0, 255)) : random_other(),
                         end_here && (i == len - 1));
         end
         sent += len;
         // new text: reshuffle the idling, now and then let the output empty first
         if (end_here) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
               wait_for_drain();
         end
      end
      // close any open run so its digits come out
      send_byte(random_other(), 1'b1);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      gaps_on = 1'b0;
      rx_mode = RX_ALWAYS;
      test_plain_bytes();
      test_short_runs();
      test_full_runs();
      wait_for_drain();

      test_output_hold_off();

      gaps_on = 1'b1;
      rx_mode = RX_RANDOM;
      test_random_texts(430);

      wait_for_drain();
      repeat (PAD_WIDTH + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
